FILE: hw/rtl/rgbau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbau_pkg
// Shared types and constants of the alpha unpremultiply and orientation core.
// ----------------------------------------------------------------------------
package rgbau_pkg;

   localparam int COLOR_W    = 8;
   localparam int NUM_COLORS = 3;
   localparam int COORD_W    = 12;
   localparam int DIM_REG_W  = 13;
   localparam int MODE_W     = 4;
   localparam int INDEX_W    = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_REG_W;
   localparam int PIPE_DEPTH = 4;

   localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIENTATION_MODE = 2'd2;

   localparam logic [MODE_W-1:0] ORIENT_TOP_LEFT     = 4'd1;
   localparam logic [MODE_W-1:0] ORIENT_TOP_RIGHT    = 4'd2;
   localparam logic [MODE_W-1:0] ORIENT_BOTTOM_RIGHT = 4'd3;
   localparam logic [MODE_W-1:0] ORIENT_BOTTOM_LEFT  = 4'd4;
   localparam logic [MODE_W-1:0] ORIENT_LEFT_TOP     = 4'd5;
   localparam logic [MODE_W-1:0] ORIENT_RIGHT_TOP    = 4'd6;
   localparam logic [MODE_W-1:0] ORIENT_RIGHT_BOTTOM = 4'd7;
   localparam logic [MODE_W-1:0] ORIENT_LEFT_BOTTOM  = 4'd8;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_column;
      logic [COORD_W-1:0] pixel_row;
      logic [COLOR_W-1:0] red_in;
      logic [COLOR_W-1:0] green_in;
      logic [COLOR_W-1:0] blue_in;
      logic [COLOR_W-1:0] alpha_in;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] dest_index;
      logic [COLOR_W-1:0] red_out;
      logic [COLOR_W-1:0] green_out;
      logic [COLOR_W-1:0] blue_out;
      logic [COLOR_W-1:0] alpha_out;
   } rsp_type;

   typedef struct packed {
      logic [DIM_REG_W-1:0] image_width;
      logic [DIM_REG_W-1:0] image_height;
      logic [MODE_W-1:0]    orientation_mode;
   } cfg_type;

endpackage
`default_nettype wire

FILE: hw/rtl/rgbau_unassoc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbau_unassoc
// Four-stage color path: (c*255 + a/2) / a through a reciprocal table,
// one multiply-back correction step, saturation to 255 and zero alpha.
// ----------------------------------------------------------------------------
module rgbau_unassoc (
   input  wire  logic                                             clock,
   input  wire  logic [rgbau_pkg::NUM_COLORS-1:0][rgbau_pkg::COLOR_W-1:0] color_in,
   input  wire  logic [rgbau_pkg::COLOR_W-1:0]                    alpha_in,
   output logic [rgbau_pkg::NUM_COLORS-1:0][rgbau_pkg::COLOR_W-1:0] color_out,
   output logic [rgbau_pkg::COLOR_W-1:0]                          alpha_out
);
   import rgbau_pkg::*;

   localparam int ALPHA_LEVELS = 1 << COLOR_W;
   localparam int RECIP_SHIFT  = 24;
   localparam int RECIP_W      = RECIP_SHIFT + 1;
   localparam int NUM_W        = 2 * COLOR_W;
   localparam int PROD_W       = NUM_W + RECIP_W;
   localparam int BACK_W       = NUM_W + COLOR_W;

   logic [RECIP_W-1:0] recip_rom [ALPHA_LEVELS];

   for (genvar gi = 0; gi < ALPHA_LEVELS; gi++) begin : g_rom
      localparam logic [RECIP_W-1:0] RECIP_VAL =
         (gi == 0) ? '0 : RECIP_W'((64'd1 << RECIP_SHIFT) / gi);
      assign recip_rom[gi] = RECIP_VAL;
   end

   logic [RECIP_W-1:0] recip1_ff;
   logic [COLOR_W-1:0] alpha1_ff;
   logic [COLOR_W-1:0] alpha2_ff;
   logic [COLOR_W-1:0] alpha3_ff;
   logic [COLOR_W-1:0] alpha4_ff;

   always_ff @(posedge clock) begin
      recip1_ff <= recip_rom[alpha_in];
      alpha1_ff <= alpha_in;
      alpha2_ff <= alpha1_ff;
      alpha3_ff <= alpha2_ff;
      alpha4_ff <= alpha3_ff;
   end

   assign alpha_out = alpha4_ff;

   for (genvar li = 0; li < NUM_COLORS; li++) begin : g_lane
      logic [NUM_W-1:0]   num_in;
      logic [NUM_W-1:0]   num1_ff;
      logic [PROD_W-1:0]  prod_in;
      logic [NUM_W-1:0]   quot2_ff;
      logic [NUM_W-1:0]   num2_ff;
      logic [BACK_W-1:0]  back_full;
      logic [NUM_W-1:0]   back3_ff;
      logic [NUM_W-1:0]   quot3_ff;
      logic [NUM_W-1:0]   num3_ff;
      logic [NUM_W-1:0]   rem;
      logic [NUM_W-1:0]   quot;
      logic [COLOR_W-1:0] color_in_v;
      logic [COLOR_W-1:0] color4_ff;

      assign num_in = (NUM_W'(color_in[li]) << COLOR_W) - NUM_W'(color_in[li])
                    + NUM_W'(alpha_in >> 1);

      assign prod_in   = PROD_W'(num1_ff) * PROD_W'(recip1_ff);
      assign back_full = BACK_W'(quot2_ff) * BACK_W'(alpha2_ff);

      // step the estimate up once when the remainder still covers alpha
      always_comb begin
         rem  = num3_ff - back3_ff;
         quot = quot3_ff + NUM_W'(rem >= NUM_W'(alpha3_ff));
         if (alpha3_ff == '0) begin
            color_in_v = '0;
         end else if (quot > NUM_W'(COLOR_MAX)) begin
            color_in_v = COLOR_MAX;
         end else begin
            color_in_v = quot[COLOR_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         num1_ff   <= num_in;
         quot2_ff  <= prod_in[RECIP_SHIFT +: NUM_W];
         num2_ff   <= num1_ff;
         back3_ff  <= back_full[NUM_W-1:0];
         quot3_ff  <= quot2_ff;
         num3_ff   <= num2_ff;
         color4_ff <= color_in_v;
      end

      assign color_out[li] = color4_ff;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/rgbau_index.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbau_index
// Four-stage destination index path: orientation mirror and stride select,
// row times stride, column add, output register. All arithmetic wraps at
// the index width.
// ----------------------------------------------------------------------------
module rgbau_index #(
   parameter int MAX_DIM = 4096
) (
   input  wire  logic                            clock,
   input  wire  rgbau_pkg::cfg_type              cfg,
   input  wire  logic [rgbau_pkg::COORD_W-1:0]   pixel_column,
   input  wire  logic [rgbau_pkg::COORD_W-1:0]   pixel_row,
   output logic [rgbau_pkg::INDEX_W-1:0]         dest_index
);
   import rgbau_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int PROD_W = INDEX_W + DIM_W;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 == 32'd0) begin
         return DIM_W'(1);
      end else if (v32 > 32'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(v32);
   endfunction

   logic [DIM_W-1:0]   width_c;
   logic [DIM_W-1:0]   height_c;
   logic [INDEX_W-1:0] x_dir;
   logic [INDEX_W-1:0] y_dir;
   logic [INDEX_W-1:0] x_flip;
   logic [INDEX_W-1:0] y_flip;
   logic [INDEX_W-1:0] row_in;
   logic [INDEX_W-1:0] col_in;
   logic [DIM_W-1:0]   stride_in;
   logic [INDEX_W-1:0] row1_ff;
   logic [INDEX_W-1:0] col1_ff;
   logic [DIM_W-1:0]   stride1_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [INDEX_W-1:0] base2_ff;
   logic [INDEX_W-1:0] col2_ff;
   logic [INDEX_W-1:0] index3_ff;
   logic [INDEX_W-1:0] index4_ff;

   always_comb begin
      width_c  = clamp_dim(cfg.image_width);
      height_c = clamp_dim(cfg.image_height);
      x_dir    = INDEX_W'(pixel_column);
      y_dir    = INDEX_W'(pixel_row);
      x_flip   = INDEX_W'(width_c) - INDEX_W'(1) - x_dir;
      y_flip   = INDEX_W'(height_c) - INDEX_W'(1) - y_dir;
      unique case (cfg.orientation_mode)
         ORIENT_TOP_RIGHT: begin
            row_in = y_dir;   col_in = x_flip; stride_in = width_c;
         end
         ORIENT_BOTTOM_RIGHT: begin
            row_in = y_flip;  col_in = x_flip; stride_in = width_c;
         end
         ORIENT_BOTTOM_LEFT: begin
            row_in = y_flip;  col_in = x_dir;  stride_in = width_c;
         end
         ORIENT_LEFT_TOP: begin
            row_in = x_dir;   col_in = y_dir;  stride_in = height_c;
         end
         ORIENT_RIGHT_TOP: begin
            row_in = x_dir;   col_in = y_flip; stride_in = height_c;
         end
         ORIENT_RIGHT_BOTTOM: begin
            row_in = x_flip;  col_in = y_flip; stride_in = height_c;
         end
         ORIENT_LEFT_BOTTOM: begin
            row_in = x_flip;  col_in = y_dir;  stride_in = height_c;
         end
         default: begin
            row_in = y_dir;   col_in = x_dir;  stride_in = width_c;
         end
      endcase
   end

   assign prod_in = PROD_W'(row1_ff) * PROD_W'(stride1_ff);

   always_ff @(posedge clock) begin
      row1_ff    <= row_in;
      col1_ff    <= col_in;
      stride1_ff <= stride_in;
      base2_ff   <= prod_in[INDEX_W-1:0];
      col2_ff    <= col1_ff;
      index3_ff  <= base2_ff + col2_ff;
      index4_ff  <= index3_ff;
   end

   assign dest_index = index4_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/rgbau_core_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_unpremultiply_orient_core
// Converts premultiplied RGBA8 pixels to straight alpha and computes each
// pixel's destination index for the configured image orientation.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_payload and raise start; the item is taken at any
//   clock edge where start is high and busy is low. busy is high only
//   while reset is asserted, so one item can enter every cycle.
//   Output: rsp_strobe marks rsp_payload for one cycle, once the item has
//   passed the color and index paths; items leave in order, one per cycle at most.
//   The receiver cannot stall; the pipeline advances every cycle.
//   Color path steps: reciprocal lookup, estimate multiply, multiply-back,
//   correct and saturate; one item per cycle sustained.
//   Config: csr_we writes csr_wdata to register csr_index (0 width,
//   1 height, 2 orientation); write only while no item is in flight.
//   Reset: clears the pipeline valid bits and loads width 1, height 1,
//   orientation 1.
// ----------------------------------------------------------------------------
module rgba_unpremultiply_orient_core #(
   parameter int MAX_DIM = 4096
) (
   input  wire  logic                                clock,
   input  wire  logic                                reset,
   input  wire  logic                                start,
   output logic                                      busy,
   input  wire  rgbau_pkg::req_type                  req_payload,
   output logic                                      rsp_strobe,
   output rgbau_pkg::rsp_type                        rsp_payload,
   input  wire  logic                                csr_we,
   input  wire  logic [rgbau_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  logic [rgbau_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rgbau_pkg::*;

   cfg_type                              cfg_ff;
   cfg_type                              cfg_in;
   logic [PIPE_DEPTH-1:0]                valid_ff;
   logic                                 accept;
   logic [NUM_COLORS-1:0][COLOR_W-1:0]   color_in;
   logic [NUM_COLORS-1:0][COLOR_W-1:0]   color_out;
   logic [COLOR_W-1:0]                   alpha_out;
   logic [INDEX_W-1:0]                   dest_index;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:      cfg_in.image_width      = csr_wdata;
            CSR_IMAGE_HEIGHT:     cfg_in.image_height     = csr_wdata;
            CSR_ORIENTATION_MODE: cfg_in.orientation_mode = csr_wdata[MODE_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= DIM_REG_W'(1);
         cfg_ff.image_height     <= DIM_REG_W'(1);
         cfg_ff.orientation_mode <= ORIENT_TOP_LEFT;
         valid_ff                <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], accept};
      end
   end

   assign color_in[0] = req_payload.red_in;
   assign color_in[1] = req_payload.green_in;
   assign color_in[2] = req_payload.blue_in;

   rgbau_unassoc u_unassoc (
      .clock     (clock),
      .color_in  (color_in),
      .alpha_in  (req_payload.alpha_in),
      .color_out (color_out),
      .alpha_out (alpha_out)
   );

   rgbau_index #(
      .MAX_DIM (MAX_DIM)
   ) u_index (
      .clock        (clock),
      .cfg          (cfg_ff),
      .pixel_column (req_payload.pixel_column),
      .pixel_row    (req_payload.pixel_row),
      .dest_index   (dest_index)
   );

   assign rsp_strobe             = valid_ff[PIPE_DEPTH-1];
   assign rsp_payload.dest_index = dest_index;
   assign rsp_payload.red_out    = color_out[0];
   assign rsp_payload.green_out  = color_out[1];
   assign rsp_payload.blue_out   = color_out[2];
   assign rsp_payload.alpha_out  = alpha_out;

endmodule
`default_nettype wire
